// ----- rtl/bsmg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded set min gap package
// Shared sizes, request, result and neighbour types, and the controller states.
// ----------------------------------------------------------------------------
package bsmg_pkg;

  localparam int SetDepth = 1024;
  localparam int AddrW    = $clog2(SetDepth);
  localparam int CountW   = 11;
  localparam int DataW    = 32;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    restart;
  } bsmg_req_t;

  typedef struct packed {
    logic              status;
    logic [CountW-1:0] held_count;
    logic [DataW-1:0]  shortest_span;
    logic [DataW-1:0]  longest_span;
    logic              spans_valid;
  } bsmg_rsp_t;

  // Neighbours of the incoming value found during a walk of the store.
  typedef struct packed {
    logic             have_pred;
    logic             have_succ;
    logic [DataW-1:0] pred;
    logic [DataW-1:0] succ;
  } bsmg_nbr_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_UPDATE,
    S_REPLY
  } bsmg_state_e;

endpackage

// ----- rtl/bsmg_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded set min gap neighbour search
// Takes one stored value a cycle and keeps the closest value at or below and
// the closest value at or above the incoming value.
// ----------------------------------------------------------------------------
module bsmg_scan import bsmg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             elem_valid_i,
  input  logic [DataW-1:0] elem_i,
  input  logic [DataW-1:0] value_i,
  output bsmg_nbr_t        nbr_o
);

  logic             have_pred_q, have_pred_d;
  logic             have_succ_q, have_succ_d;
  logic [DataW-1:0] pred_q, pred_d;
  logic [DataW-1:0] succ_q, succ_d;

  always_comb begin
    have_pred_d = have_pred_q;
    have_succ_d = have_succ_q;
    pred_d      = pred_q;
    succ_d      = succ_q;
    if (clear_i) begin
      have_pred_d = 1'b0;
      have_succ_d = 1'b0;
    end else if (elem_valid_i) begin
      if (($signed(elem_i) <= $signed(value_i)) &&
          (!have_pred_q || ($signed(elem_i) > $signed(pred_q)))) begin
        have_pred_d = 1'b1;
        pred_d      = elem_i;
      end
      if (($signed(elem_i) >= $signed(value_i)) &&
          (!have_succ_q || ($signed(elem_i) < $signed(succ_q)))) begin
        have_succ_d = 1'b1;
        succ_d      = elem_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_pred_q <= 1'b0;
      have_succ_q <= 1'b0;
    end else begin
      have_pred_q <= have_pred_d;
      have_succ_q <= have_succ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pred_q <= pred_d;
    succ_q <= succ_d;
  end

  assign nbr_o = '{have_pred: have_pred_q, have_succ: have_succ_q,
                   pred: pred_q, succ: succ_q};

endmodule

// ----- rtl/bounded_set_min_gap_and_range_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded set with minimum gap and range
// Holds up to a configured number of signed values in a simple dual-port memory
// and reports the smallest adjacent gap and the full range after each request.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                  Payload
//   request   in         req_valid_i / req_ready_o  req_i (value, restart)
//   result    out        rsp_valid_o / rsp_ready_i  rsp_o (status, count, spans)
//   config    in         cfg_we_i                   cfg_wdata_i (capacity)
//
// For an accepted value that is stored, the memory read port delivers the
// values already in the set to the neighbour search one per cycle, followed
// by a drain state, an update state and a reply state. A rejected value goes
// straight to the reply state, and one added to an empty set goes through the
// update state first.
// Reset empties the set at once; the memory itself is not cleared, since only
// entries below the fill count are ever read. A new request is taken as soon
// as the previous result sits in the output register, and a stalled result
// only holds the controller in its reply state.
// ----------------------------------------------------------------------------
module bounded_set_min_gap_and_range_top import bsmg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  input  bsmg_req_t         req_i,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output bsmg_rsp_t         rsp_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i
);

  // Controller and set summary.
  bsmg_state_e       state_q, state_d;
  logic [CountW-1:0] capacity_q;
  logic [CountW-1:0] fill_q, fill_d;
  logic [DataW-1:0]  lo_q, lo_d;
  logic [DataW-1:0]  hi_q, hi_d;
  logic [DataW-1:0]  gap_q, gap_d;
  logic              reject_q, reject_d;

  // The value under work is held for the whole walk.
  logic [DataW-1:0]  value_q;

  // Memory read side.
  logic [AddrW-1:0]  rd_idx_q, rd_idx_d;
  logic              rd_vld_q;
  logic [DataW-1:0]  rd_data_q;
  logic              mem_we;
  logic [DataW-1:0]  mem_q [SetDepth];

  // Output register.
  bsmg_rsp_t         rsp_q, rsp_d;
  logic              rsp_valid_q, rsp_valid_d;

  logic              accept;
  logic [CountW-1:0] limit;
  logic [CountW-1:0] eff_fill;
  logic              scan_clear;
  bsmg_nbr_t         nbr;
  logic [DataW-1:0]  diff_pred;
  logic [DataW-1:0]  diff_succ;
  logic [DataW-1:0]  gap_tmp;

  assign accept      = req_valid_i && req_ready_o;
  assign req_ready_o = (state_q == S_IDLE);
  assign limit       = (capacity_q > CountW'(SetDepth)) ? CountW'(SetDepth) : capacity_q;
  assign eff_fill    = req_i.restart ? '0 : fill_q;
  assign scan_clear  = accept;
  assign diff_pred   = value_q - nbr.pred;
  assign diff_succ   = nbr.succ - value_q;
  assign mem_we      = (state_q == S_UPDATE);

  bsmg_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (scan_clear),
    .elem_valid_i(rd_vld_q),
    .elem_i      (rd_data_q),
    .value_i     (value_q),
    .nbr_o       (nbr)
  );

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    gap_d       = gap_q;
    reject_d    = reject_q;
    rd_idx_d    = rd_idx_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    gap_tmp     = gap_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          // A restart empties the set before the add is tried.
          if (req_i.restart) begin
            fill_d = '0;
            lo_d   = '0;
            hi_d   = '0;
            gap_d  = '1;
          end
          rd_idx_d = '0;
          reject_d = (eff_fill >= limit);
          if (eff_fill >= limit) begin
            state_d = S_REPLY;
          end else if (eff_fill == '0) begin
            state_d = S_UPDATE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if ((CountW'(rd_idx_q) + CountW'(1)) == fill_q) begin
          state_d = S_DRAIN;
        end else begin
          rd_idx_d = rd_idx_q + AddrW'(1);
        end
      end
      S_DRAIN: begin
        // The last stored value is taken by the search in this cycle.
        state_d = S_UPDATE;
      end
      S_UPDATE: begin
        if (nbr.have_pred && (diff_pred < gap_tmp)) begin
          gap_tmp = diff_pred;
        end
        if (nbr.have_succ && (diff_succ < gap_tmp)) begin
          gap_tmp = diff_succ;
        end
        gap_d = gap_tmp;
        if (fill_q == '0) begin
          lo_d = value_q;
          hi_d = value_q;
        end else begin
          if ($signed(value_q) < $signed(lo_q)) begin
            lo_d = value_q;
          end
          if ($signed(value_q) > $signed(hi_q)) begin
            hi_d = value_q;
          end
        end
        fill_d  = fill_q + CountW'(1);
        state_d = S_REPLY;
      end
      S_REPLY: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          rsp_d.status     = reject_q;
          rsp_d.held_count = fill_q;
          if (fill_q >= CountW'(2)) begin
            rsp_d.shortest_span = gap_q;
            rsp_d.longest_span  = hi_q - lo_q;
            rsp_d.spans_valid   = 1'b1;
          end else begin
            rsp_d.shortest_span = '0;
            rsp_d.longest_span  = '0;
            rsp_d.spans_valid   = 1'b0;
          end
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      capacity_q  <= '0;
      fill_q      <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      gap_q       <= '1;
      reject_q    <= 1'b0;
      rd_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      fill_q      <= fill_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      gap_q       <= gap_d;
      reject_q    <= reject_d;
      rd_idx_q    <= rd_idx_d;
      rd_vld_q    <= (state_q == S_SCAN);
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      value_q <= req_i.value;
    end
    rsp_q <= rsp_d;
  end

  // Set storage: written at the fill position, read in order during the walk.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[fill_q[AddrW-1:0]] <= value_q;
    end
    rd_data_q <= mem_q[rd_idx_q];
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

  // The set never holds more entries than the memory has.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CountW'(SetDepth))
    else $error("fill count beyond memory depth");

  // A store only happens when there is a free entry.
  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPDATE) |-> (fill_q < CountW'(SetDepth)))
    else $error("store into a full memory");

  // Spans are only flagged with two or more values held.
  a_spans_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.spans_valid) |-> (rsp_o.held_count >= CountW'(2)))
    else $error("spans flagged with fewer than two values");

  // A request is worked on alone: no second request in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> !req_ready_o)
    else $error("request taken while another is in work");

endmodule
